// File: src/rotation_matrix_to_quaternion_assert.svh
// Assertion macros for the rotation matrix to quaternion block.
// Included by the queue and back-end modules; no other dependencies.
`ifndef ROTATION_MATRIX_TO_QUATERNION_ASSERT_SVH
`define ROTATION_MATRIX_TO_QUATERNION_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is asserted.
`define RMQ_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("rmq assertion failed");
// Next-cycle implication, disabled while reset is asserted.
`define RMQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("rmq assertion failed");
`else
`define RMQ_ASSERT_SAME(lbl, clk, rst_n, ante, cons)
`define RMQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// File: src/rmq_pkg.sv
// Shared types and constants for the rotation matrix to quaternion block.
// No dependencies.
package rmq_pkg;

	localparam int WORD_BITS_DEF = 16;
	// Request queue depth between front and back end; must be a power of two.
	localparam int QUEUE_DEPTH = 4;

	typedef enum logic [1:0] {
		BR_TRACE,
		BR_X,
		BR_Y,
		BR_Z
	} br_t;

endpackage

// File: src/rmq_in_if.sv
// Matrix input channel: valid/ready handshake with the ten matrix elements.
// Depends on nothing.
interface rmq_in_if #(parameter int W = 16);
	logic valid;
	logic ready;
	logic signed [W-1:0] m00;
	logic signed [W-1:0] m01;
	logic signed [W-1:0] m02;
	logic signed [W-1:0] m10;
	logic signed [W-1:0] m11;
	logic signed [W-1:0] m12;
	logic signed [W-1:0] m20;
	logic signed [W-1:0] m21;
	logic signed [W-1:0] m22;
	logic signed [W-1:0] m33;

	modport source (output valid, m00, m01, m02, m10, m11, m12, m20, m21, m22, m33,
		input ready);
	modport sink (input valid, m00, m01, m02, m10, m11, m12, m20, m21, m22, m33,
		output ready);
endinterface

// File: src/rmq_out_if.sv
// Quaternion output channel: valid/ready handshake with the result fields.
// Depends on nothing.
interface rmq_out_if #(parameter int W = 16);
	logic valid;
	logic ready;
	logic signed [W-1:0] qx;
	logic signed [W-1:0] qy;
	logic signed [W-1:0] qz;
	logic signed [W-1:0] qw;
	logic invalid;
	logic [1:0] branch;

	modport source (output valid, qx, qy, qz, qw, invalid, branch, input ready);
	modport sink (input valid, qx, qy, qz, qw, invalid, branch, output ready);
endinterface

// File: src/rmq_front.sv
// Front end: accepts a matrix, picks the branch, forms the square-root
// argument and the three quotient numerators. Depends on rmq_pkg, rmq_in_if.
module rmq_front import rmq_pkg::*; #(
	parameter int W = WORD_BITS_DEF,
	localparam int EW = 4 * (W + 1) + 3
) (
	rmq_in_if.sink mat,
	input logic full,
	output logic push,
	output logic [EW-1:0] entry
);

	localparam int F = W - 2;
	localparam int TW = W + 2;
	localparam int NW = W + 1;
	localparam logic signed [TW-1:0] ONE = TW'(1) << F;

	logic signed [TW-1:0] e00, e11, e22, e33;
	logic signed [TW-1:0] t_tr, t_nt, t_sel;
	logic signed [NW-1:0] p01, p02, p12, d01, d20, d12;
	logic signed [NW-1:0] n0, n1, n2;
	logic is_tr, inv;
	br_t br;

	assign e00 = TW'(mat.m00);
	assign e11 = TW'(mat.m11);
	assign e22 = TW'(mat.m22);
	assign e33 = TW'(mat.m33);

	assign p01 = NW'(mat.m01) + NW'(mat.m10);
	assign p02 = NW'(mat.m02) + NW'(mat.m20);
	assign p12 = NW'(mat.m12) + NW'(mat.m21);
	assign d01 = NW'(mat.m01) - NW'(mat.m10);
	assign d20 = NW'(mat.m20) - NW'(mat.m02);
	assign d12 = NW'(mat.m12) - NW'(mat.m21);

	assign t_tr = e00 + e11 + e22 + e33;
	assign is_tr = (t_tr >= ONE);

	always_comb begin
		br_t big;
		big = (e00 <= e11) ? BR_Y : BR_X;
		if (e22 > ((big == BR_Y) ? e11 : e00)) begin
			big = BR_Z;
		end
		// Numerators are listed in output order, skipping the slot of the
		// component that comes from the square root itself.
		if (is_tr) begin
			br = BR_TRACE;
			t_nt = t_tr;
			n0 = d12;
			n1 = d20;
			n2 = d01;
		end else begin
			br = big;
			unique case (big)
				BR_X: begin
					t_nt = e00 - e11 - e22 + ONE;
					n0 = p01;
					n1 = p02;
					n2 = d12;
				end
				BR_Y: begin
					t_nt = e11 - e22 - e00 + ONE;
					n0 = p01;
					n1 = p12;
					n2 = d20;
				end
				default: begin
					t_nt = e22 - e00 - e11 + ONE;
					n0 = p02;
					n1 = p12;
					n2 = d01;
				end
			endcase
		end
	end

	assign t_sel = t_nt;
	assign inv = !is_tr && (t_sel[TW-1] || t_sel == '0);

	assign push = mat.valid && !full;
	assign mat.ready = !full;
	assign entry = {br, inv, t_sel[W:0], n2, n1, n0};

endmodule

// File: src/rmq_queue.sv
// Short request queue that decouples the front end from the back end.
// Depends on the assertion macro header.
`include "rotation_matrix_to_quaternion_assert.svh"
module rmq_queue #(
	parameter int DW = 8,
	parameter int DEPTH = 4
) (
	input logic clk,
	input logic arst_n,
	input logic push,
	input logic [DW-1:0] wdata,
	output logic full,
	input logic pop,
	output logic rvalid,
	output logic [DW-1:0] rdata
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [DW-1:0] mem_q [DEPTH];
	logic [PW-1:0] wr_q, rd_q;
	logic [CW-1:0] count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + PW'(1);
			end
			if (pop) begin
				rd_q <= rd_q + PW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= wdata;
		end
	end

	assign full = (count_q == CW'(DEPTH));
	assign rvalid = (count_q != '0);
	assign rdata = mem_q[rd_q];

	`RMQ_ASSERT_SAME(a_count_bound, clk, arst_n, 1'b1, count_q <= CW'(DEPTH))
	`RMQ_ASSERT_NEXT(a_count_up, clk, arst_n, push && !pop, count_q == $past(count_q) + CW'(1))
	`RMQ_ASSERT_NEXT(a_count_dn, clk, arst_n, pop && !push, count_q == $past(count_q) - CW'(1))

endmodule

// File: src/rmq_back.sv
// Back end: pipelined square root, three pipelined dividers, saturation and
// the output register. Depends on rmq_pkg, rmq_out_if and the assertion macros.
`include "rotation_matrix_to_quaternion_assert.svh"
module rmq_back import rmq_pkg::*; #(
	parameter int W = WORD_BITS_DEF,
	localparam int EW = 4 * (W + 1) + 3
) (
	input logic clk,
	input logic arst_n,
	input logic q_valid,
	input logic [EW-1:0] q_data,
	output logic q_pop,
	rmq_out_if.source quat
);

	localparam int F = W - 2;
	localparam int NW = W + 1;
	localparam int RB = W + 3;
	localparam int QB = 2 * W - 1;
	localparam int RD = W + 1;
	localparam logic [QB-1:0] LIM = QB'(1) << (W - 1);

	typedef struct packed {
		logic [2*W-1:0] rad;
		logic [RB-1:0] rem;
		logic [W-1:0] root;
		logic [2:0][NW-1:0] num;
		br_t br;
		logic inv;
	} sq_t;

	typedef struct packed {
		logic [2:0][QB-1:0] mag;
		logic [2:0][RD-1:0] rem;
		logic [2:0][QB-1:0] quo;
		logic [2:0] neg;
		logic [W:0] den;
		logic [W-2:0] half;
		br_t br;
		logic inv;
	} dv_t;

	sq_t sqrt_s [W+1];
	sq_t sqrt_nx [W];
	dv_t div_s [QB+1];
	dv_t div_nx [QB];
	dv_t div_init;
	logic [W:0] sqrt_v;
	logic [QB:0] div_v;
	logic en;

	logic out_v_q, inv_q;
	logic signed [W-1:0] qx_q, qy_q, qz_q, qw_q;
	br_t br_q;
	logic [2:0][W-1:0] lane;
	logic [W-1:0] half_w;
	logic [W-1:0] rx, ry, rz, rw;

	// The whole back end advances together unless the output is held.
	assign en = !out_v_q || quat.ready;
	assign q_pop = en && q_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sqrt_v <= '0;
			div_v <= '0;
		end else if (en) begin
			sqrt_v <= {sqrt_v[W-1:0], q_valid};
			div_v <= {div_v[QB-1:0], sqrt_v[W]};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sqrt_s[0].rad <= {1'b0, q_data[4*NW-1:3*NW], {F{1'b0}}};
			sqrt_s[0].rem <= '0;
			sqrt_s[0].root <= '0;
			sqrt_s[0].num <= q_data[3*NW-1:0];
			sqrt_s[0].inv <= q_data[4*NW];
			sqrt_s[0].br <= br_t'(q_data[4*NW+2:4*NW+1]);
		end
	end

	// One result bit of the square root per stage.
	for (genvar k = 0; k < W; k++) begin : g_sqrt
		always_comb begin
			logic [RB-1:0] remx, trial;
			logic ge;
			remx = {sqrt_s[k].rem[RB-3:0], sqrt_s[k].rad[2*W-1 -: 2]};
			trial = {1'b0, sqrt_s[k].root, 2'b01};
			ge = (remx >= trial);
			sqrt_nx[k] = sqrt_s[k];
			sqrt_nx[k].rad = sqrt_s[k].rad << 2;
			sqrt_nx[k].rem = ge ? remx - trial : remx;
			sqrt_nx[k].root = {sqrt_s[k].root[W-2:0], ge};
		end
		always_ff @(posedge clk) begin
			if (en) begin
				sqrt_s[k+1] <= sqrt_nx[k];
			end
		end
	end

	always_comb begin
		logic [NW-1:0] mabs;
		div_init.den = {sqrt_s[W].root, 1'b0};
		div_init.half = sqrt_s[W].root[W-1:1];
		div_init.br = sqrt_s[W].br;
		div_init.inv = sqrt_s[W].inv;
		div_init.rem = '0;
		div_init.quo = '0;
		for (int l = 0; l < 3; l++) begin
			div_init.neg[l] = sqrt_s[W].num[l][NW-1];
			mabs = div_init.neg[l] ? NW'(-sqrt_s[W].num[l]) : sqrt_s[W].num[l];
			div_init.mag[l] = {mabs, {F{1'b0}}};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			div_s[0] <= div_init;
		end
	end

	// One quotient bit per stage in each of the three lanes.
	for (genvar k = 0; k < QB; k++) begin : g_div
		always_comb begin
			logic [RD:0] sh;
			logic ge;
			div_nx[k] = div_s[k];
			for (int l = 0; l < 3; l++) begin
				sh = {div_s[k].rem[l], div_s[k].mag[l][QB-1]};
				ge = (sh >= {1'b0, div_s[k].den});
				div_nx[k].rem[l] = ge ? RD'(sh - {1'b0, div_s[k].den}) : RD'(sh);
				div_nx[k].mag[l] = div_s[k].mag[l] << 1;
				div_nx[k].quo[l] = {div_s[k].quo[l][QB-2:0], ge};
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				div_s[k+1] <= div_nx[k];
			end
		end
	end

	always_comb begin
		for (int l = 0; l < 3; l++) begin
			if (!div_s[QB].neg[l]) begin
				lane[l] = (div_s[QB].quo[l] >= LIM) ? {1'b0, {(W-1){1'b1}}}
					: div_s[QB].quo[l][W-1:0];
			end else begin
				lane[l] = (div_s[QB].quo[l] > LIM) ? {1'b1, {(W-1){1'b0}}}
					: W'(-div_s[QB].quo[l][W-1:0]);
			end
		end
		half_w = {1'b0, div_s[QB].half};
		unique case (div_s[QB].br)
			BR_TRACE: begin
				rx = lane[0]; ry = lane[1]; rz = lane[2]; rw = half_w;
			end
			BR_X: begin
				rx = half_w; ry = lane[0]; rz = lane[1]; rw = lane[2];
			end
			BR_Y: begin
				rx = lane[0]; ry = half_w; rz = lane[1]; rw = lane[2];
			end
			default: begin
				rx = lane[0]; ry = lane[1]; rz = half_w; rw = lane[2];
			end
		endcase
		if (div_s[QB].inv) begin
			rx = '0; ry = '0; rz = '0; rw = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (en) begin
			out_v_q <= div_v[QB];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			qx_q <= rx;
			qy_q <= ry;
			qz_q <= rz;
			qw_q <= rw;
			inv_q <= div_s[QB].inv;
			br_q <= div_s[QB].br;
		end
	end

	assign quat.valid = out_v_q;
	assign quat.qx = qx_q;
	assign quat.qy = qy_q;
	assign quat.qz = qz_q;
	assign quat.qw = qw_q;
	assign quat.invalid = inv_q;
	assign quat.branch = br_q;

	`RMQ_ASSERT_SAME(a_inv_zero, clk, arst_n, out_v_q && inv_q, {qx_q, qy_q, qz_q, qw_q} == '0)
	`RMQ_ASSERT_SAME(a_trace_valid, clk, arst_n, out_v_q && br_q == BR_TRACE, !inv_q)
	`RMQ_ASSERT_NEXT(a_stall_hold, clk, arst_n, out_v_q && !quat.ready, div_v == $past(div_v))

endmodule

// File: src/rotation_matrix_to_quaternion.sv
// Rotation matrix to quaternion (Shepperd's method), Q2.14 at the default width.
// Pipeline: queue, input register, WORD_BITS-stage square root, divider input register,
// 2*WORD_BITS-1 stage dividers, then the output register.
// Throughput: one request per cycle while the output is not held; a 4-entry queue absorbs output stalls.
// Reset: asynchronous, active low; clears the queue and all stage valid bits.
// Depends on rmq_pkg, rmq_in_if, rmq_out_if, rmq_front, rmq_queue, rmq_back.
module rotation_matrix_to_quaternion import rmq_pkg::*; #(
	parameter int WORD_BITS = WORD_BITS_DEF
) (
	input logic clk,
	input logic arst_n,
	rmq_in_if.sink mat,
	rmq_out_if.source quat
);

	localparam int EW = 4 * (WORD_BITS + 1) + 3;

	logic push, full, pop, rvalid;
	logic [EW-1:0] entry, rdata;

	rmq_front #(.W(WORD_BITS)) u_front (
		.mat(mat),
		.full(full),
		.push(push),
		.entry(entry)
	);

	rmq_queue #(.DW(EW), .DEPTH(QUEUE_DEPTH)) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.wdata(entry),
		.full(full),
		.pop(pop),
		.rvalid(rvalid),
		.rdata(rdata)
	);

	rmq_back #(.W(WORD_BITS)) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.q_valid(rvalid),
		.q_data(rdata),
		.q_pop(pop),
		.quat(quat)
	);

endmodule
